// File: rtl/eustc_pkg.sv
// eustc_pkg: constants and helpers for the eu summer time correction unit
`default_nettype none

package eustc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned OFFS_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_STD_OFFSET    = 2'd0;
  localparam cfg_idx_t REG_SUMMER_OFFSET = 2'd1;

  localparam logic [OFFS_W-1:0] STD_OFFSET_RST    = 16'd3600;
  localparam logic [OFFS_W-1:0] SUMMER_OFFSET_RST = 16'd7200;

  // reciprocal constants, exact over the value ranges seen in the pipeline
  localparam logic [27:0] RECIP_675  = 28'd203613265; // shift 37
  localparam logic [16:0] RECIP_7    = 17'd74899;     // shift 19
  localparam logic [17:0] RECIP_1460 = 18'd183861;    // shift 28
  localparam logic [17:0] RECIP_365  = 18'd183861;    // shift 26

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;

  localparam logic [19:0] EPOCH_DAYS  = 20'd719468;
  localparam logic [19:0] ERA4_START  = 20'd584388;
  localparam logic [19:0] ERA5_START  = 20'd730485;

  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_OCT = 4'd10;
  localparam logic [4:0] LAST_DAY0 = 5'd30;

  typedef logic [2:0] wday_t;
  localparam wday_t SUNDAY = 3'd0;

  // first day of each month in the march-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/eu_summer_time_correction_unit.sv
// eu_summer_time_correction_unit: utc epoch seconds to local seconds with eu summer time
// throughput: one transaction per cycle while out_ready does not stall, seven register stages with valid bits
// each stage holds its transaction under back-pressure and fills bubbles
// reset: synchronous active-low rst_n clears all valid bits
// reset: offsets return to 3600 s standard and 7200 s summer
`default_nettype none

module eu_summer_time_correction_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [eustc_pkg::TIME_W-1:0]  in_utc_seconds,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [eustc_pkg::TIME_W-1:0]       out_local_seconds,
  output logic                               out_summer_active,
  input  wire logic                          cfg_we,
  input  wire eustc_pkg::cfg_idx_t           cfg_index,
  input  wire logic [eustc_pkg::OFFS_W-1:0]  cfg_data
);

  logic [eustc_pkg::OFFS_W-1:0] std_off_r, sum_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_off_r <= eustc_pkg::STD_OFFSET_RST;
      sum_off_r <= eustc_pkg::SUMMER_OFFSET_RST;
    end else if (cfg_we) begin
      if (cfg_index == eustc_pkg::REG_STD_OFFSET) std_off_r <= cfg_data;
      if (cfg_index == eustc_pkg::REG_SUMMER_OFFSET) sum_off_r <= cfg_data;
    end
  end

  // stage valids and advance chain
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, out_v_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

  assign adv7 = !out_v_r || out_ready;
  assign adv6 = !s6_v_r || adv7;
  assign adv5 = !s5_v_r || adv6;
  assign adv4 = !s4_v_r || adv5;
  assign adv3 = !s3_v_r || adv4;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;

  assign in_ready  = adv1;
  assign out_valid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r  <= in_valid;
      if (adv2) s2_v_r  <= s1_v_r;
      if (adv3) s3_v_r  <= s2_v_r;
      if (adv4) s4_v_r  <= s3_v_r;
      if (adv5) s5_v_r  <= s4_v_r;
      if (adv6) s6_v_r  <= s5_v_r;
      if (adv7) out_v_r <= s6_v_r;
    end
  end

  // stage 1: day count
  logic [52:0] s1_prod;
  logic [15:0] s1_days_nxt;
  logic [31:0] s1_t_r;
  logic [15:0] s1_days_r;

  assign s1_prod     = 53'(in_utc_seconds[31:7]) * 53'(eustc_pkg::RECIP_675);
  assign s1_days_nxt = s1_prod[52:37];

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_t_r    <= in_utc_seconds;
      s1_days_r <= s1_days_nxt;
    end
  end

  // stage 2: hour flag, weekday quotient, day of era
  logic [32:0] s2_dsec;
  logic [32:0] s2_sod_full;
  logic [15:0] s2_x;
  logic [32:0] s2_wprod;
  logic [19:0] s2_z;
  logic [19:0] s2_doe_full;
  logic [31:0] s2_t_r;
  logic        s2_hflag_r;
  logic [15:0] s2_x_r;
  logic [12:0] s2_wq_r;
  logic [17:0] s2_doe_r;

  assign s2_dsec     = 33'(s1_days_r) * 33'(eustc_pkg::SECS_PER_DAY);
  assign s2_sod_full = {1'b0, s1_t_r} - s2_dsec;
  assign s2_x        = s1_days_r + 16'd4;
  assign s2_wprod    = 33'(s2_x) * 33'(eustc_pkg::RECIP_7);
  assign s2_z        = 20'(s1_days_r) + eustc_pkg::EPOCH_DAYS;
  assign s2_doe_full = (s2_z >= eustc_pkg::ERA5_START) ? s2_z - eustc_pkg::ERA5_START
                                                       : s2_z - eustc_pkg::ERA4_START;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_t_r     <= s1_t_r;
      s2_hflag_r <= (s2_sod_full[16:0] >= eustc_pkg::SECS_PER_HOUR);
      s2_x_r     <= s2_x;
      s2_wq_r    <= s2_wprod[31:19];
      s2_doe_r   <= s2_doe_full[17:0];
    end
  end

  // stage 3: weekday, corrected day of era for year split
  logic [15:0] s3_wfull;
  logic [35:0] s3_cprod;
  logic [6:0]  s3_c1460;
  logic [2:0]  s3_c36524;
  logic        s3_c146096;
  logic [17:0] s3_n_nxt;
  logic [31:0] s3_t_r;
  logic        s3_hflag_r;
  eustc_pkg::wday_t s3_wday_r;
  logic [17:0] s3_doe_r;
  logic [17:0] s3_n_r;

  assign s3_wfull   = s2_x_r - 16'({s2_wq_r, 3'b000} - 16'(s2_wq_r));
  assign s3_cprod   = 36'(s2_doe_r) * 36'(eustc_pkg::RECIP_1460);
  assign s3_c1460   = s3_cprod[34:28];
  assign s3_c36524  = 3'(s2_doe_r >= 18'd36524) + 3'(s2_doe_r >= 18'd73048)
                    + 3'(s2_doe_r >= 18'd109572) + 3'(s2_doe_r >= 18'd146096);
  assign s3_c146096 = (s2_doe_r == 18'd146096);
  assign s3_n_nxt   = s2_doe_r - 18'(s3_c1460) + 18'(s3_c36524) - 18'(s3_c146096);

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_t_r     <= s2_t_r;
      s3_hflag_r <= s2_hflag_r;
      s3_wday_r  <= s3_wfull[2:0];
      s3_doe_r   <= s2_doe_r;
      s3_n_r     <= s3_n_nxt;
    end
  end

  // stage 4: year of era
  logic [35:0] s4_yprod;
  logic [31:0] s4_t_r;
  logic        s4_hflag_r;
  eustc_pkg::wday_t s4_wday_r;
  logic [17:0] s4_doe_r;
  logic [8:0]  s4_yoe_r;

  assign s4_yprod = 36'(s3_n_r) * 36'(eustc_pkg::RECIP_365);

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_t_r     <= s3_t_r;
      s4_hflag_r <= s3_hflag_r;
      s4_wday_r  <= s3_wday_r;
      s4_doe_r   <= s3_doe_r;
      s4_yoe_r   <= s4_yprod[34:26];
    end
  end

  // stage 5: day of year
  logic [17:0] s5_ydays;
  logic [1:0]  s5_c100;
  logic [17:0] s5_doy_full;
  logic [31:0] s5_t_r;
  logic        s5_hflag_r;
  eustc_pkg::wday_t s5_wday_r;
  logic [8:0]  s5_doy_r;

  assign s5_c100     = 2'(s4_yoe_r >= 9'd100) + 2'(s4_yoe_r >= 9'd200)
                     + 2'(s4_yoe_r >= 9'd300);
  assign s5_ydays    = 18'(s4_yoe_r) * 18'd365 + 18'(s4_yoe_r[8:2]) - 18'(s5_c100);
  assign s5_doy_full = s4_doe_r - s5_ydays;

  always_ff @(posedge clk) begin
    if (adv5) begin
      s5_t_r     <= s4_t_r;
      s5_hflag_r <= s4_hflag_r;
      s5_wday_r  <= s4_wday_r;
      s5_doy_r   <= s5_doy_full[8:0];
    end
  end

  // stage 6: month and day of month
  logic [3:0]  s6_mp;
  logic [8:0]  s6_dom0;
  logic [3:0]  s6_month_nxt;
  logic [31:0] s6_t_r;
  logic        s6_hflag_r;
  eustc_pkg::wday_t s6_wday_r;
  logic [3:0]  s6_month_r;
  logic [4:0]  s6_day0_r;

  always_comb begin
    s6_mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (s5_doy_r >= eustc_pkg::month_start(4'(i))) s6_mp = s6_mp + 4'd1;
    end
  end

  assign s6_dom0      = s5_doy_r - eustc_pkg::month_start(s6_mp);
  assign s6_month_nxt = (s6_mp < 4'd10) ? s6_mp + 4'd3 : s6_mp - 4'd9;

  always_ff @(posedge clk) begin
    if (adv6) begin
      s6_t_r     <= s5_t_r;
      s6_hflag_r <= s5_hflag_r;
      s6_wday_r  <= s5_wday_r;
      s6_month_r <= s6_month_nxt;
      s6_day0_r  <= s6_dom0[4:0];
    end
  end

  // stage 7: switch decision and offset add
  logic [5:0]  s7_next_sun;
  logic        s7_after;
  logic        s7_summer;
  logic [31:0] s7_local;
  logic [31:0] out_local_r;
  logic        out_summer_r;

  assign s7_next_sun = 6'(s6_day0_r) + 6'(3'd7 - s6_wday_r);

  always_comb begin
    if (s7_next_sun <= 6'(eustc_pkg::LAST_DAY0)) begin
      s7_after = 1'b0;
    end else if (s6_wday_r == eustc_pkg::SUNDAY) begin
      s7_after = s6_hflag_r;
    end else begin
      s7_after = 1'b1;
    end
    if (s6_month_r > eustc_pkg::MONTH_MAR && s6_month_r < eustc_pkg::MONTH_OCT) begin
      s7_summer = 1'b1;
    end else if (s6_month_r < eustc_pkg::MONTH_MAR || s6_month_r > eustc_pkg::MONTH_OCT) begin
      s7_summer = 1'b0;
    end else if (s6_month_r == eustc_pkg::MONTH_MAR) begin
      s7_summer = s7_after;
    end else begin
      s7_summer = !s7_after;
    end
  end

  assign s7_local = s6_t_r + 32'(s7_summer ? sum_off_r : std_off_r);

  always_ff @(posedge clk) begin
    if (adv7) begin
      out_local_r  <= s7_local;
      out_summer_r <= s7_summer;
    end
  end

  assign out_local_seconds = out_local_r;
  assign out_summer_active = out_summer_r;

  // checks
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_v_r)
    else $error("accepted transaction did not reach stage 1");

  a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> s3_wday_r <= 3'd6)
    else $error("weekday out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    s6_v_r |-> (s6_month_r >= 4'd1 && s6_month_r <= 4'd12))
    else $error("month out of range");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv2 |=> s1_v_r && $stable(s1_t_r) && $stable(s1_days_r))
    else $error("stalled stage 1 lost its transaction");

endmodule

`default_nettype wire

// File: tb/eu_summer_time_correction_unit_tb.sv
// testbench for the eu summer time correction unit with a self-checking local time predictor
`timescale 1ns / 1ps

module eu_summer_time_correction_unit_tb;

  localparam int unsigned CLK_HALF_NS  = 5;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned TIMEOUT_NS   = 4_000_000;
  localparam int unsigned IDLE_MAX     = 13;

  localparam int unsigned SECS_DAY   = 86400;
  localparam int unsigned SECS_HOUR  = 3600;
  localparam int unsigned DAYS_WEEK  = 7;
  localparam int unsigned EPOCH_SHIFT = 719468;
  localparam int unsigned DAYS_ERA   = 146097;

  localparam eustc_pkg::cfg_idx_t REG_UNUSED_2 = 2'd2;
  localparam eustc_pkg::cfg_idx_t REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic [eustc_pkg::TIME_W-1:0] local_secs;
    logic                         summer;
  } local_time_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [eustc_pkg::TIME_W-1:0] in_utc_seconds;
  logic                         out_valid;
  logic                         out_ready;
  logic [eustc_pkg::TIME_W-1:0] out_local_seconds;
  logic                         out_summer_active;
  logic                         cfg_we;
  eustc_pkg::cfg_idx_t          cfg_index;
  logic [eustc_pkg::OFFS_W-1:0] cfg_data;

  logic [eustc_pkg::OFFS_W-1:0] std_offset;
  logic [eustc_pkg::OFFS_W-1:0] summer_offset;

  logic [eustc_pkg::TIME_W-1:0] pending_stamps[$];
  local_time_t                  expected_times[$];

  bit          in_taken;
  bit          out_taken;
  bit          hold_go;
  int unsigned hold_left;
  int unsigned send_wait;
  int unsigned recv_wait;
  int unsigned send_idle_max;
  int unsigned recv_idle_max;
  int unsigned fail_count;

  eu_summer_time_correction_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_utc_seconds    (in_utc_seconds),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_local_seconds (out_local_seconds),
    .out_summer_active (out_summer_active),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  function automatic local_time_t predict_local(input logic [eustc_pkg::TIME_W-1:0] utc);
    int unsigned days, hour, wday, z, era, doe, yoe, doy, mp, mday, month;
    int unsigned day0, first_sun, last_sun;
    bit          after_switch;
    bit          summer;
    local_time_t r;
    days = utc / SECS_DAY;
    hour = (utc % SECS_DAY) / SECS_HOUR;
    wday = (days + 4) % DAYS_WEEK;
    z    = days + EPOCH_SHIFT;
    era  = z / DAYS_ERA;
    doe  = z - era * DAYS_ERA;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    mday = doy - (153 * mp + 2) / 5 + 1;
    month = (mp < 10) ? mp + 3 : mp - 9;
    if (month > eustc_pkg::MONTH_MAR && month < eustc_pkg::MONTH_OCT) begin
      summer = 1'b1;
    end else if (month < eustc_pkg::MONTH_MAR || month > eustc_pkg::MONTH_OCT) begin
      summer = 1'b0;
    end else begin
      // zero-based day of month of the last sunday
      day0      = mday - 1;
      first_sun = (day0 + DAYS_WEEK - wday) % DAYS_WEEK;
      last_sun  = first_sun
                + DAYS_WEEK * ((int'(eustc_pkg::LAST_DAY0) - first_sun) / DAYS_WEEK);
      if (last_sun != day0) begin
        after_switch = (last_sun < day0);
      end else begin
        after_switch = (hour >= 1);
      end
      summer = (month == eustc_pkg::MONTH_MAR) ? after_switch : !after_switch;
    end
    r.summer     = summer;
    r.local_secs = utc + (summer ? summer_offset : std_offset);
    return r;
  endfunction

  function automatic logic [eustc_pkg::TIME_W-1:0] civil_to_stamp(input int yr, input int mo,
                                                                  input int dy, input int secs);
    int    y, era, yoe, doy, doe, days;
    longint total;
    y    = yr - ((mo <= 2) ? 1 : 0);
    era  = y / 400;
    yoe  = y - era * 400;
    doy  = (153 * ((mo > 2) ? mo - 3 : mo + 9) + 2) / 5 + dy - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * int'(DAYS_ERA) + doe - int'(EPOCH_SHIFT);
    total = longint'(days) * SECS_DAY + secs;
    return total[eustc_pkg::TIME_W-1:0];
  endfunction

  // mostly dates near the march and october switch, the rest anywhere or just below the top of the 32-bit range
  function automatic logic [eustc_pkg::TIME_W-1:0] random_stamp();
    int unsigned pick;
    int          yr, mo, dy, secs;
    pick = $urandom_range(0, 99);
    if (pick < 20) return $urandom;
    if (pick < 27) return 32'hFFFF_FFFF - $urandom_range(0, 200000);
    yr = $urandom_range(1970, 2105);
    if (pick < 42) begin
      mo   = $urandom_range(1, 12);
      dy   = $urandom_range(1, 28);
      secs = $urandom_range(0, SECS_DAY - 1);
    end else begin
      mo = ($urandom_range(0, 1) != 0) ? int'(eustc_pkg::MONTH_MAR) : int'(eustc_pkg::MONTH_OCT);
      dy = $urandom_range(18, 31);
      if (pick < 60) begin
        secs = $urandom_range(0, SECS_DAY - 1);
      end else if (pick < 85) begin
        secs = $urandom_range(0, 3 * SECS_HOUR);
      end else begin
        secs = $urandom_range(SECS_HOUR - 2, SECS_HOUR + 1);
      end
    end
    return civil_to_stamp(yr, mo, dy, secs);
  endfunction

  task automatic report_error(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic write_reg(input eustc_pkg::cfg_idx_t idx,
                           input logic [eustc_pkg::OFFS_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == eustc_pkg::REG_STD_OFFSET) begin
      std_offset = val;
    end else if (idx == eustc_pkg::REG_SUMMER_OFFSET) begin
      summer_offset = val;
    end
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) pending_stamps.push_back(random_stamp());
  endtask

  task automatic wait_idle();
    while (pending_stamps.size() != 0 || in_valid || expected_times.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_stamps.size() > 0) begin
          in_utc_seconds <= pending_stamps.pop_front();
          in_valid       <= 1'b1;
          send_wait = $urandom_range(0, send_idle_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready
  always @(negedge clk) begin
    if (!rst_n || hold_left > 0) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        recv_wait = $urandom_range(0, recv_idle_max);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go   = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // monitor
  always @(posedge clk) begin
    local_time_t exp_time;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (expected_times.size() == 0) begin
          report_error($sformatf("unexpected transaction: local %0d summer %0b",
                                 out_local_seconds, out_summer_active));
        end else begin
          exp_time = expected_times.pop_front();
          if (out_local_seconds !== exp_time.local_secs ||
              out_summer_active !== exp_time.summer) begin
            report_error($sformatf("mismatch: expected local %0d summer %0b, got local %0d summer %0b",
                                   exp_time.local_secs, exp_time.summer,
                                   out_local_seconds, out_summer_active));
          end
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        expected_times.push_back(predict_local(in_utc_seconds));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("eu_summer_time_correction_unit_tb failed");
    $finish;
  end

  initial begin
    logic [eustc_pkg::TIME_W-1:0] directed[$];
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_utc_seconds = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = eustc_pkg::REG_STD_OFFSET;
    cfg_data       = '0;
    std_offset     = eustc_pkg::STD_OFFSET_RST;
    summer_offset  = eustc_pkg::SUMMER_OFFSET_RST;
    send_idle_max  = IDLE_MAX;
    recv_idle_max  = IDLE_MAX;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset offsets, calendar edges and switch instants
    directed.push_back(32'h0000_0000);
    directed.push_back(32'hFFFF_FFFF);
    directed.push_back(32'h7FFF_FFFF);
    directed.push_back(32'h8000_0000);
    directed.push_back(civil_to_stamp(2024, 3, 31, SECS_HOUR - 1));
    directed.push_back(civil_to_stamp(2024, 3, 31, SECS_HOUR));
    directed.push_back(civil_to_stamp(2024, 3, 30, SECS_DAY - 1));
    directed.push_back(civil_to_stamp(2024, 3, 24, 2 * SECS_HOUR));
    directed.push_back(civil_to_stamp(2018, 3, 25, SECS_HOUR - 1));
    directed.push_back(civil_to_stamp(2018, 3, 25, SECS_HOUR));
    directed.push_back(civil_to_stamp(2018, 3, 31, 12 * SECS_HOUR));
    directed.push_back(civil_to_stamp(2024, 10, 27, SECS_HOUR - 1));
    directed.push_back(civil_to_stamp(2024, 10, 27, SECS_HOUR));
    directed.push_back(civil_to_stamp(2024, 10, 26, SECS_DAY - 1));
    directed.push_back(civil_to_stamp(2024, 10, 31, 0));
    directed.push_back(civil_to_stamp(2021, 10, 31, SECS_HOUR - 1));
    directed.push_back(civil_to_stamp(2021, 10, 31, SECS_HOUR));
    directed.push_back(civil_to_stamp(2024, 4, 1, 0));
    directed.push_back(civil_to_stamp(2024, 9, 30, SECS_DAY - 1));
    directed.push_back(civil_to_stamp(2024, 11, 1, 0));
    directed.push_back(civil_to_stamp(2024, 2, 29, 12 * SECS_HOUR));
    directed.push_back(civil_to_stamp(2024, 6, 15, 0));
    directed.push_back(civil_to_stamp(2024, 12, 31, SECS_DAY - 1));
    directed.push_back(civil_to_stamp(2105, 10, 25, SECS_HOUR));
    foreach (directed[i]) pending_stamps.push_back(directed[i]);
    wait_idle();

    // no idling on either side
    write_reg(eustc_pkg::REG_STD_OFFSET, 16'd0);
    write_reg(eustc_pkg::REG_SUMMER_OFFSET, 16'd50400);
    send_idle_max = 0;
    recv_idle_max = 0;
    queue_random(300);
    wait_idle();

    write_reg(eustc_pkg::REG_STD_OFFSET, 16'd50400);
    write_reg(eustc_pkg::REG_SUMMER_OFFSET, 16'd0);
    send_idle_max = IDLE_MAX;
    recv_idle_max = IDLE_MAX;
    queue_random(300);
    wait_idle();

    // all-ones offsets, ignored indexes, receiver hold-off to fill the pipeline
    write_reg(eustc_pkg::REG_STD_OFFSET, 16'hFFFF);
    write_reg(eustc_pkg::REG_SUMMER_OFFSET, 16'hFFFF);
    write_reg(REG_UNUSED_2, 16'($urandom));
    write_reg(REG_UNUSED_3, 16'($urandom));
    send_idle_max = 0;
    recv_idle_max = 3;
    queue_random(300);
    @(negedge clk);
    hold_go = 1'b1;
    wait_idle();

    write_reg(eustc_pkg::REG_STD_OFFSET, eustc_pkg::STD_OFFSET_RST);
    write_reg(eustc_pkg::REG_SUMMER_OFFSET, eustc_pkg::SUMMER_OFFSET_RST);
    send_idle_max = IDLE_MAX;
    recv_idle_max = 3;
    queue_random(340);
    wait_idle();

    write_reg(eustc_pkg::REG_STD_OFFSET, 16'($urandom_range(0, 65535)));
    write_reg(eustc_pkg::REG_SUMMER_OFFSET, 16'($urandom_range(0, 65535)));
    send_idle_max = 3;
    recv_idle_max = IDLE_MAX;
    queue_random(340);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_times.size() == 0) begin
      $display("eu_summer_time_correction_unit_tb passed");
    end else begin
      $display("eu_summer_time_correction_unit_tb failed");
    end
    $finish;
  end

endmodule
